### src/cpc_pkg.sv
// Shared types, constants and helpers of the chromaticity pixel classifier.
package cpc_pkg;

   localparam int NUM_CLASSES    = 6;
   localparam int REFS_PER_CLASS = 2;
   localparam int NUM_GROUPS     = 4;
   localparam int REFS_PER_GROUP = 3;
   localparam int CHROMA_W       = 10;
   localparam int REF_W          = 2 * CHROMA_W;
   localparam int GROUP_W        = REFS_PER_GROUP * REF_W;
   localparam int DIST_W         = 21;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = GROUP_W;
   localparam int QUEUE_DEPTH    = 8;
   localparam int LEVEL_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int FRONT_STAGES   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_BRIGHTNESS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_REL_SAT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REJECT_DIST    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REF_GROUP_0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REF_GROUP_1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REF_GROUP_2    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REF_GROUP_3    = 3'd6;

   localparam logic [1:0] OUT_CLASSIFIED = 2'd0;
   localparam logic [1:0] OUT_DARK       = 2'd1;
   localparam logic [1:0] OUT_UNSAT      = 2'd2;
   localparam logic [1:0] OUT_FAR        = 2'd3;

   typedef struct packed {
      logic [7:0] blue_level;
      logic [7:0] green_level;
      logic [7:0] red_level;
   } req_type;

   typedef struct packed {
      logic              is_colored;
      logic [2:0]        color_index;
      logic [1:0]        outcome;
      logic [DIST_W-1:0] best_dist_sq;
   } rsp_type;

   typedef struct packed {
      logic [7:0]                           min_brightness;
      logic [8:0]                           min_rel_saturation;
      logic [DIST_W-1:0]                    reject_dist_sq;
      logic [NUM_GROUPS-1:0][GROUP_W-1:0]   ref_group;
   } cfg_type;

   // Request after the front end: gating verdict and rg chromaticity.
   typedef struct packed {
      logic [1:0]          gate;
      logic [CHROMA_W-1:0] chroma_r;
      logic [CHROMA_W-1:0] chroma_g;
   } chroma_type;

   function automatic int tree_levels(input int num_refs);
      return (num_refs > 1) ? $clog2(num_refs) : 1;
   endfunction

endpackage

### src/chromaticity_pixel_classifier.sv
// Top level: configuration registers, front end, request queue and back end.
// The minimum tree has T = ceil(log2(N)) levels over N = NUM_CLASSES*REFS_PER_CLASS
// references (at least one level), twelve by default. Throughput: one pixel per clock
// while busy is low; the divider and the minimum tree are fully pipelined.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is synchronous: it empties all pipelines and the queue, clears every
// configuration register to zero, and holds busy high while it lasts.
module chromaticity_pixel_classifier #(
   parameter int NUM_CLASSES    = cpc_pkg::NUM_CLASSES,
   parameter int REFS_PER_CLASS = cpc_pkg::REFS_PER_CLASS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cpc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output cpc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [cpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int TreeLevels = cpc_pkg::tree_levels(NUM_CLASSES * REFS_PER_CLASS);
   localparam int Latency    = 9 + TreeLevels;

   cpc_pkg::cfg_type              cfg_ff;
   cpc_pkg::cfg_type              cfg_in;
   logic                          req_accept;
   logic                          front_valid;
   cpc_pkg::chroma_type           front_data;
   logic                          queue_valid;
   cpc_pkg::chroma_type           queue_data;
   logic [cpc_pkg::LEVEL_W-1:0]   queue_level;

   // Hold off requests when the queue could not absorb everything in the front end.
   assign busy = reset
              || (queue_level > cpc_pkg::LEVEL_W'(cpc_pkg::QUEUE_DEPTH - cpc_pkg::FRONT_STAGES));
   assign req_accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cpc_pkg::REG_MIN_BRIGHTNESS: cfg_in.min_brightness     = csr_wdata[7:0];
            cpc_pkg::REG_MIN_REL_SAT:    cfg_in.min_rel_saturation = csr_wdata[8:0];
            cpc_pkg::REG_REJECT_DIST:    cfg_in.reject_dist_sq     = csr_wdata[cpc_pkg::DIST_W-1:0];
            cpc_pkg::REG_REF_GROUP_0:    cfg_in.ref_group[0]       = csr_wdata;
            cpc_pkg::REG_REF_GROUP_1:    cfg_in.ref_group[1]       = csr_wdata;
            cpc_pkg::REG_REF_GROUP_2:    cfg_in.ref_group[2]       = csr_wdata;
            cpc_pkg::REG_REF_GROUP_3:    cfg_in.ref_group[3]       = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   cpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   cpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop_valid (queue_valid),
      .pop_data  (queue_data),
      .level     (queue_level)
   );

   cpc_back #(
      .NUM_CLASSES    (NUM_CLASSES),
      .REFS_PER_CLASS (REFS_PER_CLASS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_data   (queue_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##Latency rsp_valid)
      else $error("accepted request produced no result strobe");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, Latency))
      else $error("result strobe without a matching accepted request");

endmodule

### src/cpc_div.sv
// Two-stage pipelined restoring divider for chroma = channel*1023 / sum.
module cpc_div (
   input  logic                          clock,
   input  logic [17:0]                   num,
   input  logic [9:0]                    den,
   output logic [cpc_pkg::CHROMA_W-1:0]  quot
);

   logic [9:0] rem_a_ff;
   logic [4:0] q_hi_ff;
   logic [4:0] num_lo_ff;
   logic [9:0] den_a_ff;
   logic [9:0] quot_ff;

   logic [14:0] step_a;
   logic [14:0] step_b;

   // Five quotient bits; returns the remainder in the upper ten bits.
   function automatic logic [14:0] div_steps(input logic [9:0] rem, input logic [4:0] bits,
                                             input logic [9:0] d);
      logic [10:0] t;
      logic [9:0]  r;
      logic [4:0]  q;
      r = rem;
      q = '0;
      for (int i = 4; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, d}) begin
            r    = 10'(t - {1'b0, d});
            q[i] = 1'b1;
         end else begin
            r = t[9:0];
         end
      end
      return {r, q};
   endfunction

   // The quotient stays below 1024, so the top eight numerator bits are
   // already a valid partial remainder.
   assign step_a = div_steps({2'b00, num[17:10]}, num[9:5], den);
   assign step_b = div_steps(rem_a_ff, num_lo_ff, den_a_ff);

   always_ff @(posedge clock) begin
      rem_a_ff  <= step_a[14:5];
      q_hi_ff   <= step_a[4:0];
      num_lo_ff <= num[4:0];
      den_a_ff  <= den;
      quot_ff   <= {q_hi_ff, step_b[4:0]};
   end

   assign quot = quot_ff;

endmodule

### src/cpc_front.sv
// Front end: brightness and saturation gating and rg chromaticity division.
module cpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cpc_pkg::req_type     in_data,
   input  cpc_pkg::cfg_type     cfg,
   output logic                 out_valid,
   output cpc_pkg::chroma_type  out_data
);

   typedef struct packed {
      logic       valid;
      logic [1:0] gate;
      logic       sum_zero;
   } front_side_type;

   logic             f1_valid_ff;
   cpc_pkg::req_type f1_pix_ff;

   front_side_type   f2_side_ff;
   front_side_type   f3_side_ff;
   front_side_type   f4_side_ff;
   front_side_type   f2_side_in;
   logic [17:0]      num_r_ff;
   logic [17:0]      num_g_ff;
   logic [9:0]       den_ff;

   logic [7:0]       hi;
   logic [7:0]       lo;
   logic [7:0]       spread;
   logic [9:0]       sum;
   logic             dark;
   logic             unsat;
   logic [16:0]      sat_lhs;
   logic [16:0]      sat_rhs;
   logic [cpc_pkg::CHROMA_W-1:0] quot_r;
   logic [cpc_pkg::CHROMA_W-1:0] quot_g;

   always_comb begin
      hi = f1_pix_ff.red_level;
      lo = f1_pix_ff.red_level;
      if (f1_pix_ff.green_level > hi) hi = f1_pix_ff.green_level;
      if (f1_pix_ff.blue_level > hi) hi = f1_pix_ff.blue_level;
      if (f1_pix_ff.green_level < lo) lo = f1_pix_ff.green_level;
      if (f1_pix_ff.blue_level < lo) lo = f1_pix_ff.blue_level;
      spread  = hi - lo;
      sum     = 10'(f1_pix_ff.red_level) + 10'(f1_pix_ff.green_level)
              + 10'(f1_pix_ff.blue_level);
      sat_lhs = {1'b0, spread, 8'h00};
      sat_rhs = 17'(cfg.min_rel_saturation) * 17'(hi);
      dark    = hi < cfg.min_brightness;
      // A black pixel has no saturation at all.
      unsat   = (hi == 8'd0) ? (cfg.min_rel_saturation != 9'd0) : (sat_lhs < sat_rhs);

      f2_side_in.valid    = f1_valid_ff;
      f2_side_in.sum_zero = sum == 10'd0;
      priority if (dark) begin
         f2_side_in.gate = cpc_pkg::OUT_DARK;
      end else if (unsat) begin
         f2_side_in.gate = cpc_pkg::OUT_UNSAT;
      end else begin
         f2_side_in.gate = cpc_pkg::OUT_CLASSIFIED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_side_ff  <= '0;
         f3_side_ff  <= '0;
         f4_side_ff  <= '0;
      end else begin
         f1_valid_ff <= in_valid;
         f2_side_ff  <= f2_side_in;
         f3_side_ff  <= f2_side_ff;
         f4_side_ff  <= f3_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_pix_ff <= in_data;
      num_r_ff  <= {f1_pix_ff.red_level, 10'b0} - {10'b0, f1_pix_ff.red_level};
      num_g_ff  <= {f1_pix_ff.green_level, 10'b0} - {10'b0, f1_pix_ff.green_level};
      den_ff    <= sum;
   end

   cpc_div u_div_r (
      .clock (clock),
      .num   (num_r_ff),
      .den   (den_ff),
      .quot  (quot_r)
   );

   cpc_div u_div_g (
      .clock (clock),
      .num   (num_g_ff),
      .den   (den_ff),
      .quot  (quot_g)
   );

   assign out_valid         = f4_side_ff.valid;
   assign out_data.gate     = f4_side_ff.gate;
   assign out_data.chroma_r = f4_side_ff.sum_zero ? '0 : quot_r;
   assign out_data.chroma_g = f4_side_ff.sum_zero ? '0 : quot_g;

endmodule

### src/cpc_queue.sv
// Short request queue between the front end and the matching back end.
module cpc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  cpc_pkg::chroma_type           push_data,
   output logic                          pop_valid,
   output cpc_pkg::chroma_type           pop_data,
   output logic [cpc_pkg::LEVEL_W-1:0]   level
);

   localparam int PtrW = $clog2(cpc_pkg::QUEUE_DEPTH);

   cpc_pkg::chroma_type           mem_ff [cpc_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]               wr_ptr_ff;
   logic [PtrW-1:0]               rd_ptr_ff;
   logic [cpc_pkg::LEVEL_W-1:0]   level_ff;
   logic [cpc_pkg::LEVEL_W-1:0]   level_in;
   logic                          pop;

   // The back end never stalls, so any waiting request leaves at once.
   assign pop = level_ff != '0;

   always_comb begin
      level_in = level_ff;
      unique case ({push, pop})
         2'b10:   level_in = level_ff + cpc_pkg::LEVEL_W'(1);
         2'b01:   level_in = level_ff - cpc_pkg::LEVEL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= PtrW'(wr_ptr_ff + 1'b1);
         if (pop) rd_ptr_ff <= PtrW'(rd_ptr_ff + 1'b1);
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_valid = pop;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && (level_ff == cpc_pkg::LEVEL_W'(cpc_pkg::QUEUE_DEPTH))))
      else $error("request pushed into a full queue");

endmodule

### src/cpc_back.sv
// Back end: squared distances to the references and a registered minimum tree.
module cpc_back #(
   parameter int NUM_CLASSES    = cpc_pkg::NUM_CLASSES,
   parameter int REFS_PER_CLASS = cpc_pkg::REFS_PER_CLASS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cpc_pkg::chroma_type  in_data,
   input  cpc_pkg::cfg_type     cfg,
   output logic                 rsp_valid,
   output cpc_pkg::rsp_type     rsp_data
);

   localparam int NumRefs    = NUM_CLASSES * REFS_PER_CLASS;
   localparam int TreeLevels = cpc_pkg::tree_levels(NumRefs);
   localparam int Leaves     = 1 << TreeLevels;
   localparam int Nodes      = 2 * Leaves - 1;
   localparam int IdxW       = TreeLevels;
   localparam int SideStages = 3 + TreeLevels;
   localparam int ChromaW    = cpc_pkg::CHROMA_W;
   localparam int DistW      = cpc_pkg::DIST_W;

   typedef struct packed {
      logic       valid;
      logic [1:0] gate;
   } back_side_type;

   back_side_type                 side_ff [SideStages];
   logic [ChromaW-1:0]            chroma_r_ff;
   logic [ChromaW-1:0]            chroma_g_ff;
   logic [2*ChromaW-1:0]          sq_r_ff [NumRefs];
   logic [2*ChromaW-1:0]          sq_g_ff [NumRefs];
   logic                          node_live_ff [Nodes];
   logic [DistW-1:0]              node_dist_ff [Nodes];
   logic [IdxW-1:0]               node_idx_ff  [Nodes];

   back_side_type                 last_side;
   logic                          far;
   cpc_pkg::rsp_type              rsp_in;
   logic                          rsp_valid_ff;
   cpc_pkg::rsp_type              rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else begin
         side_ff[0].valid <= in_valid;
         side_ff[0].gate  <= in_data.gate;
      end
   end

   always_ff @(posedge clock) begin
      chroma_r_ff <= in_data.chroma_r;
      chroma_g_ff <= in_data.chroma_g;
   end

   for (genvar s = 1; s < SideStages; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) side_ff[s] <= '0;
         else side_ff[s] <= side_ff[s-1];
      end
   end

   // One lane per reference: differences and squares.
   for (genvar k = 0; k < NumRefs; k++) begin : g_lane
      localparam int Grp = k / cpc_pkg::REFS_PER_GROUP;
      localparam int Sh  = (k % cpc_pkg::REFS_PER_GROUP) * cpc_pkg::REF_W;
      logic signed [ChromaW:0]     dr;
      logic signed [ChromaW:0]     dg;
      logic signed [2*ChromaW+1:0] pr;
      logic signed [2*ChromaW+1:0] pg;
      assign dr = $signed({1'b0, chroma_r_ff})
                - $signed({1'b0, cfg.ref_group[Grp][Sh +: ChromaW]});
      assign dg = $signed({1'b0, chroma_g_ff})
                - $signed({1'b0, cfg.ref_group[Grp][Sh + ChromaW +: ChromaW]});
      assign pr = dr * dr;
      assign pg = dg * dg;
      always_ff @(posedge clock) begin
         sq_r_ff[k] <= pr[2*ChromaW-1:0];
         sq_g_ff[k] <= pg[2*ChromaW-1:0];
      end
   end

   // Leaves of the tree; unused leaves never win.
   for (genvar k = 0; k < Leaves; k++) begin : g_leaf
      if (k < NumRefs) begin : g_real
         always_ff @(posedge clock) begin
            node_live_ff[Leaves-1+k] <= 1'b1;
            node_dist_ff[Leaves-1+k] <= DistW'(sq_r_ff[k]) + DistW'(sq_g_ff[k]);
            node_idx_ff[Leaves-1+k]  <= IdxW'(k);
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_live_ff[Leaves-1+k] <= 1'b0;
            node_dist_ff[Leaves-1+k] <= '0;
            node_idx_ff[Leaves-1+k]  <= '0;
         end
      end
   end

   // The left child covers lower reference indexes, so it keeps ties.
   for (genvar n = 0; n < Leaves - 1; n++) begin : g_node
      logic take_right;
      assign take_right = node_live_ff[2*n+2] && (node_dist_ff[2*n+2] < node_dist_ff[2*n+1]);
      always_ff @(posedge clock) begin
         node_live_ff[n] <= node_live_ff[2*n+1] || node_live_ff[2*n+2];
         node_dist_ff[n] <= take_right ? node_dist_ff[2*n+2] : node_dist_ff[2*n+1];
         node_idx_ff[n]  <= take_right ? node_idx_ff[2*n+2] : node_idx_ff[2*n+1];
      end
   end

   always_comb begin
      last_side = side_ff[SideStages-1];
      far       = (cfg.reject_dist_sq != '0) && (node_dist_ff[0] > cfg.reject_dist_sq);
      rsp_in    = '0;
      priority if (last_side.gate != cpc_pkg::OUT_CLASSIFIED) begin
         rsp_in.outcome = last_side.gate;
      end else if (far || !node_live_ff[0]) begin
         rsp_in.outcome      = cpc_pkg::OUT_FAR;
         rsp_in.best_dist_sq = node_dist_ff[0];
      end else begin
         rsp_in.is_colored   = 1'b1;
         rsp_in.color_index  = 3'(node_idx_ff[0] / REFS_PER_CLASS);
         rsp_in.outcome      = cpc_pkg::OUT_CLASSIFIED;
         rsp_in.best_dist_sq = node_dist_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= last_side.valid;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_label_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_colored == (rsp_data_ff.outcome == cpc_pkg::OUT_CLASSIFIED)))
      else $error("colored flag disagrees with outcome");

   a_gated_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.outcome == cpc_pkg::OUT_DARK
                       || rsp_data_ff.outcome == cpc_pkg::OUT_UNSAT)
      |-> (rsp_data_ff.best_dist_sq == '0) && (rsp_data_ff.color_index == '0))
      else $error("gated pixel carries a distance or class");

endmodule
